// File: rtl/gps_pkg.sv
package gps_pkg;

	// Grain store geometry (power of two length)
	localparam int GRAIN_LEN = 1024;
	localparam int GRAIN_AW  = $clog2(GRAIN_LEN);
	localparam int FADE_W    = GRAIN_AW + 1;
	localparam int PHASE_W   = GRAIN_AW + 16;

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 18;
	localparam int MIX_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	// Shared multiplier geometry
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_ENABLE = 2'd2;

	// Register reset values
	localparam logic [STEP_W-1:0] PHASE_STEP_RST = 18'd65536;
	localparam logic [MIX_W-1:0]  MIX_LEVEL_RST  = 16'd26214;

	// Fixed point constants
	localparam logic [31:0]        PI_Q30    = 32'd3373259426;
	localparam logic [30:0]        ONE_Q30   = 31'd1073741824;
	localparam logic [MIX_W-1:0]   UNITY_Q15 = 16'd32768;
	localparam logic [PHASE_W:0]   PHASE_LIM = (PHASE_W + 1)'(GRAIN_LEN) << 16;

	// Taylor series denominators of the sine Horner steps
	function automatic logic [6:0] horner_div(input logic [1:0] j);
		logic [6:0] d;
		unique case (j)
			2'd0: d = 7'd72;
			2'd1: d = 7'd42;
			2'd2: d = 7'd20;
			2'd3: d = 7'd6;
			default: d = 7'd6;
		endcase
		return d;
	endfunction

	// floor(2^32 / d) for each denominator, quotient low by at most one
	function automatic logic [29:0] horner_recip(input logic [1:0] j);
		logic [29:0] m;
		unique case (j)
			2'd0: m = 30'd59652323;
			2'd1: m = 30'd102261126;
			2'd2: m = 30'd214748364;
			2'd3: m = 30'd715827882;
			default: m = 30'd715827882;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/gps_ram.sv
module gps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/gps_mul.sv
module gps_mul import gps_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// signed multiply, product registered
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

// File: rtl/granular_pitch_shifter_top.sv
// Granular pitch shifter, single grain, Q15 audio.
// Input stream: one beat per audio sample on s_axis; output stream: one beat
// per input beat on m_axis, in order. Registers are written on the cfg channel
// (index 0 phase step, 1 mix level, 2 effect enable); the user must write
// them only while idle, as the block does not enforce it. Every sample runs
// through a small sequencer that drives one shared registered 33x33
// multiplier; the sine series of the two Hann lookups, the reciprocal
// divisions, interpolation and mixing all go through it in turn.
// Bypass goes straight to the output state; with the effect on and the store
// not yet full only the mix runs; with it full, the sequencer reads and
// interpolates two stored samples, runs the window and fade Hann lookups and
// mixes. The input is ready again in the cycle after the result is loaded.
// The output register holds a finished beat while the receiver stalls; the
// next sample is taken meanwhile and its result waits in the sequencer.
// Reset: registers take their defaults, phase, fade and write position clear
// and the store counts as empty; no clearing pass is needed.
module granular_pitch_shifter_top import gps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream; tdata: [15:0] sample_in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,
	// output stream; tdata: [15:0] sample_out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [15:0]           m_axis_tdata,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RD0  = 5'd1;
	localparam logic [4:0] ST_RD1  = 5'd2;
	localparam logic [4:0] ST_IP0  = 5'd3;
	localparam logic [4:0] ST_IP1  = 5'd4;
	localparam logic [4:0] ST_IP2  = 5'd5;
	localparam logic [4:0] ST_HU   = 5'd6;
	localparam logic [4:0] ST_HX   = 5'd7;
	localparam logic [4:0] ST_HXM  = 5'd8;
	localparam logic [4:0] ST_HX2  = 5'd9;
	localparam logic [4:0] ST_DM   = 5'd10;
	localparam logic [4:0] ST_DQ   = 5'd11;
	localparam logic [4:0] ST_DC   = 5'd12;
	localparam logic [4:0] ST_DR   = 5'd13;
	localparam logic [4:0] ST_HAM  = 5'd14;
	localparam logic [4:0] ST_HAV  = 5'd15;
	localparam logic [4:0] ST_HS   = 5'd16;
	localparam logic [4:0] ST_HSS  = 5'd17;
	localparam logic [4:0] ST_HHM  = 5'd18;
	localparam logic [4:0] ST_HH   = 5'd19;
	localparam logic [4:0] ST_WM   = 5'd20;
	localparam logic [4:0] ST_WR   = 5'd21;
	localparam logic [4:0] ST_FM   = 5'd22;
	localparam logic [4:0] ST_FR   = 5'd23;
	localparam logic [4:0] ST_MX0  = 5'd24;
	localparam logic [4:0] ST_MX1  = 5'd25;
	localparam logic [4:0] ST_MX2  = 5'd26;
	localparam logic [4:0] ST_OUT  = 5'd27;

	// control state
	logic [4:0]          state_q;
	logic [GRAIN_AW-1:0] wp_q;
	logic                full_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [FADE_W-1:0]   fc_q;
	logic [STEP_W-1:0]   step_q;
	logic [MIX_W-1:0]    mix_q;
	logic                en_q;
	logic                out_valid_q;
	logic [1:0]          j_q;
	logic                hsel_q;

	// datapath registers
	logic signed [15:0]  x_in_q;
	logic signed [15:0]  s0_q;
	logic signed [15:0]  s1_q;
	logic signed [33:0]  acc_q;
	logic signed [15:0]  r_q;
	logic [FADE_W-1:0]   k_q;
	logic [30:0]         x_q;
	logic [31:0]         x2_q;
	logic [31:0]         v_q;
	logic [29:0]         q_q;
	logic [30:0]         a_q;
	logic [30:0]         s_q;
	logic [15:0]         h_q;
	logic signed [15:0]  win_q;
	logic signed [15:0]  wet_q;
	logic [15:0]         res_q;
	logic [15:0]         out_q;

	// shared multiplier and store
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] p;
	logic [GRAIN_AW-1:0]      raddr;
	logic [15:0]              rdata;

	logic                     in_beat;
	logic                     out_free;
	logic                     full_next;
	logic [GRAIN_AW-1:0]      i0;
	logic [GRAIN_AW-1:0]      i1;
	logic [15:0]              frac;
	logic [16:0]              frac_inv;
	logic [16:0]              t_pos;
	logic [16:0]              u_pos;
	logic [FADE_W-1:0]        fc_inc;
	logic [FADE_W-1:0]        fc_new;
	logic [PHASE_W:0]         psum;
	logic [MIX_W-1:0]         mix_sat;
	logic [MIX_W-1:0]         dry_w;
	logic [6:0]               hdiv;
	logic [31:0]              rem;
	logic [29:0]              q_fix;
	logic [30:0]              s_raw;
	logic [30:0]              s_val;
	logic [61:0]              hsum;
	logic [16:0]              h_raw;
	logic [15:0]              h_val;
	logic signed [33:0]       isum;
	logic signed [33:0]       wsum;
	logic signed [33:0]       ysum;
	logic signed [18:0]       y_wide;
	logic [15:0]              y_sat;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// read phase split and store addressing
	assign i0        = phase_q[PHASE_W-1:16];
	assign i1        = i0 + 1'b1;
	assign frac      = phase_q[15:0];
	assign frac_inv  = 17'h10000 - {1'b0, frac};
	assign full_next = full_q || (wp_q == GRAIN_AW'(GRAIN_LEN - 1));
	assign raddr     = (state_q == ST_RD1) ? i1 : i0;

	// Hann argument folded onto its rising half
	assign t_pos = 17'(k_q[GRAIN_AW-1:0]) << (16 - GRAIN_AW);
	assign u_pos = (t_pos <= 17'd32768) ? t_pos : 17'h10000 - t_pos;

	// fade step and phase step
	assign fc_inc = fc_q + 1'b1;
	assign fc_new = (fc_inc > FADE_W'(GRAIN_LEN)) ? '0 : fc_inc;
	assign psum   = (PHASE_W + 1)'(phase_q) + (PHASE_W + 1)'(step_q);

	assign mix_sat = (mix_q > UNITY_Q15) ? UNITY_Q15 : mix_q;
	assign dry_w   = UNITY_Q15 - mix_sat;

	// reciprocal division correction
	assign hdiv  = horner_div(j_q);
	assign rem   = v_q - p[31:0];
	assign q_fix = q_q + 30'(rem >= 32'(hdiv));

	// sine clamp and Hann square
	assign s_raw = p[60:30];
	assign s_val = (s_raw > ONE_Q30) ? ONE_Q30 : s_raw;
	assign hsum  = p[61:0] + (62'd1 << 44);
	assign h_raw = hsum[61:45];
	assign h_val = (h_raw > 17'(UNITY_Q15)) ? UNITY_Q15 : h_raw[15:0];

	// rounding sums, half toward plus infinity
	assign isum   = acc_q + $signed(p[33:0]) + 34'sd32768;
	assign wsum   = $signed(p[33:0]) + 34'sd16384;
	assign ysum   = acc_q + $signed(p[33:0]) + 34'sd16384;
	assign y_wide = ysum[33:15];

	always_comb begin
		if (y_wide > 19'sd32767) begin
			y_sat = 16'h7FFF;
		end else if (y_wide < -19'sd32768) begin
			y_sat = 16'h8000;
		end else begin
			y_sat = y_wide[15:0];
		end
	end

	// multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_IP0: begin
				mul_a = MUL_W'(s0_q);
				mul_b = $signed(MUL_W'(frac_inv));
			end
			ST_IP1: begin
				mul_a = MUL_W'(s1_q);
				mul_b = $signed(MUL_W'(frac));
			end
			ST_HU: begin
				mul_a = $signed(MUL_W'(u_pos));
				mul_b = $signed(MUL_W'(PI_Q30));
			end
			ST_HXM: begin
				mul_a = $signed(MUL_W'(x_q));
				mul_b = $signed(MUL_W'(x_q));
			end
			ST_DM: begin
				mul_a = $signed(MUL_W'(v_q));
				mul_b = $signed(MUL_W'(horner_recip(j_q)));
			end
			ST_DC: begin
				mul_a = $signed(MUL_W'(q_q));
				mul_b = $signed(MUL_W'(hdiv));
			end
			ST_HAM: begin
				mul_a = $signed(MUL_W'(x2_q));
				mul_b = $signed(MUL_W'(a_q));
			end
			ST_HS: begin
				mul_a = $signed(MUL_W'(x_q));
				mul_b = $signed(MUL_W'(a_q));
			end
			ST_HHM: begin
				mul_a = $signed(MUL_W'(s_q));
				mul_b = $signed(MUL_W'(s_q));
			end
			ST_WM: begin
				mul_a = MUL_W'(r_q);
				mul_b = $signed(MUL_W'(h_q));
			end
			ST_FM: begin
				mul_a = MUL_W'(win_q);
				mul_b = $signed(MUL_W'(h_q));
			end
			ST_MX0: begin
				mul_a = MUL_W'(x_in_q);
				mul_b = $signed(MUL_W'(dry_w));
			end
			ST_MX1: begin
				mul_a = MUL_W'(wet_q);
				mul_b = $signed(MUL_W'(mix_sat));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	gps_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (p)
	);

	gps_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (GRAIN_LEN)
	) u_store (
		.clk   (clk),
		.we    (in_beat && en_q),
		.waddr (wp_q),
		.wdata (s_axis_tdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			full_q      <= 1'b0;
			phase_q     <= '0;
			fc_q        <= '0;
			step_q      <= PHASE_STEP_RST;
			mix_q       <= MIX_LEVEL_RST;
			en_q        <= 1'b0;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			hsel_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PHASE_STEP:    step_q <= cfg_data[STEP_W-1:0];
					CFG_MIX_LEVEL:     mix_q  <= cfg_data[MIX_W-1:0];
					CFG_EFFECT_ENABLE: en_q   <= cfg_data[0];
					default: ;
				endcase
			end

			// output register: load a finished beat, drop it once taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (en_q) begin
							wp_q    <= wp_q + 1'b1;
							full_q  <= full_next;
							state_q <= full_next ? ST_RD0 : ST_MX0;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_IP0;
				ST_IP0:  state_q <= ST_IP1;
				ST_IP1:  state_q <= ST_IP2;
				ST_IP2: begin
					hsel_q  <= 1'b0;
					state_q <= ST_HU;
				end
				ST_HU:   state_q <= ST_HX;
				ST_HX:   state_q <= ST_HXM;
				ST_HXM:  state_q <= ST_HX2;
				ST_HX2: begin
					j_q     <= '0;
					state_q <= ST_DM;
				end
				ST_DM:   state_q <= ST_DQ;
				ST_DQ:   state_q <= ST_DC;
				ST_DC:   state_q <= ST_DR;
				ST_DR: begin
					if (j_q == 2'd3) begin
						state_q <= ST_HS;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_HAM;
					end
				end
				ST_HAM:  state_q <= ST_HAV;
				ST_HAV:  state_q <= ST_DM;
				ST_HS:   state_q <= ST_HSS;
				ST_HSS:  state_q <= ST_HHM;
				ST_HHM:  state_q <= ST_HH;
				ST_HH:   state_q <= hsel_q ? ST_FM : ST_WM;
				ST_WM:   state_q <= ST_WR;
				ST_WR: begin
					fc_q    <= fc_new;
					hsel_q  <= 1'b1;
					state_q <= ST_HU;
				end
				ST_FM:   state_q <= ST_FR;
				ST_FR:   state_q <= ST_MX0;
				ST_MX0: begin
					// phase wrap restarts the fade
					if (psum >= PHASE_LIM) begin
						phase_q <= PHASE_W'(psum - PHASE_LIM);
						fc_q    <= '0;
					end else begin
						phase_q <= psum[PHASE_W-1:0];
					end
					state_q <= ST_MX1;
				end
				ST_MX1:  state_q <= ST_MX2;
				ST_MX2:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					x_in_q <= $signed(s_axis_tdata);
					res_q  <= s_axis_tdata;
					wet_q  <= '0;
				end
			end
			ST_RD1: s0_q <= $signed(rdata);
			ST_IP0: s1_q <= $signed(rdata);
			ST_IP1: acc_q <= p[33:0];
			ST_IP2: begin
				r_q <= isum[31:16];
				k_q <= FADE_W'(i0);
			end
			ST_HX:  x_q <= p[46:16];
			ST_HX2: begin
				x2_q <= p[61:30];
				v_q  <= p[61:30];
			end
			ST_DQ:  q_q <= p[61:32];
			ST_DR:  a_q <= ONE_Q30 - 31'(q_fix);
			ST_HAV: v_q <= p[61:30];
			ST_HSS: s_q <= s_val;
			ST_HH:  h_q <= h_val;
			ST_WR: begin
				win_q <= wsum[30:15];
				k_q   <= fc_new;
			end
			ST_FR:  wet_q <= wsum[30:15];
			ST_MX1: acc_q <= p[33:0];
			ST_MX2: res_q <= y_sat;
			ST_OUT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// reciprocal quotient is never more than one low
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DR |-> rem < (32'(hdiv) << 1))
		else $error("horner quotient off by more than one");

	// bypass beat goes straight to the output stage with the input value
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && !en_q |=> state_q == ST_OUT && res_q == $past(s_axis_tdata))
		else $error("bypass beat not forwarded");

	// fade count stays within one grain
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |=> fc_q <= FADE_W'(GRAIN_LEN))
		else $error("fade count out of range");

	// a stalled output keeps the finished sample waiting in the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_valid_q && !m_axis_tready |=> state_q == ST_OUT)
		else $error("result overran stalled output");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;
	import gps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int RAND_ITEMS  = 1530;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 100;
	localparam int DIR_ROWS    = 27;

	// index 3 has no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	localparam longint unsigned PI_Q30_C  = 64'd3373259426;
	localparam longint unsigned ONE_Q30_C = 64'd1 << 30;
	localparam int unsigned     PHASE_END = GRAIN_LEN * 65536;

	typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [SAMPLE_W-1:0]   sample;
		bit                    has_fixed;
		logic [SAMPLE_W-1:0]   fixed;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shifter model state and register copies
	logic signed [15:0] p_store [GRAIN_LEN];
	int unsigned        p_wr_pos;
	bit                 p_full;
	int unsigned        p_phase;
	int unsigned        p_fade;
	logic [STEP_W-1:0]  p_step;
	logic [MIX_W-1:0]   p_mix;
	bit                 p_enable;
	longint             hann_tab [GRAIN_LEN];

	logic [SAMPLE_W-1:0] expected_out_q [$];
	bit                  dir_fixed_valid = 1'b0;
	logic [SAMPLE_W-1:0] dir_fixed_out = '0;
	bit                  hold_off_req = 1'b0;
	int                  err_cnt = 0;
	int                  cycle_cnt = 0;
	dir_row_t            dir_tab [DIR_ROWS];

	granular_pitch_shifter_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// round half up, then floor: same as an arithmetic shift of the biased value
	function automatic longint round_shift(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	// sin^2 window in Q15 via truncated Taylor series of sine in Q30
	function automatic longint hann_calc(input int k);
		longint unsigned t, u, xq, x2, a, s, h;
		t = k % GRAIN_LEN;
		t = (t << 16) / GRAIN_LEN;
		u = (t <= 32768) ? t : 65536 - t;
		xq = (u * PI_Q30_C) >> 16;
		x2 = (xq * xq) >> 30;
		a = ONE_Q30_C - x2 / 72;
		a = ONE_Q30_C - ((x2 * a) >> 30) / 42;
		a = ONE_Q30_C - ((x2 * a) >> 30) / 20;
		a = ONE_Q30_C - ((x2 * a) >> 30) / 6;
		s = (xq * a) >> 30;
		if (s > ONE_Q30_C)
			s = ONE_Q30_C;
		h = (s * s + (64'd1 << 44)) >> 45;
		if (h > 32768)
			h = 32768;
		return longint'(h);
	endfunction

	// one sample through the shifter model; updates the model state
	function automatic logic [SAMPLE_W-1:0] shift_sample(input logic [SAMPLE_W-1:0] raw);
		int          x;
		int unsigned i0, i1;
		longint      s0, s1, f, r, win, wet, m, y;
		x = $signed(raw);
		wet = 0;
		if (!p_enable)
			return raw;
		p_store[p_wr_pos] = raw;
		p_wr_pos = (p_wr_pos + 1) % GRAIN_LEN;
		if (p_wr_pos == 0)
			p_full = 1'b1;
		if (p_full) begin
			i0 = (p_phase >> 16) % GRAIN_LEN;
			i1 = (i0 + 1) % GRAIN_LEN;
			f = p_phase & 32'hFFFF;
			s0 = p_store[i0];
			s1 = p_store[i1];
			r = round_shift(s0 * (65536 - f) + s1 * f, 16);
			win = round_shift(r * hann_tab[i0], 15);
			p_fade++;
			if (p_fade > GRAIN_LEN)
				p_fade = 0;
			wet = round_shift(win * hann_tab[p_fade % GRAIN_LEN], 15);
		end
		p_phase += p_step;
		if (p_phase >= PHASE_END) begin
			p_phase -= PHASE_END;
			p_fade = 0;
		end
		m = (p_mix > UNITY_Q15) ? 32768 : p_mix;
		y = round_shift(longint'(x) * (32768 - m) + wet * m, 15);
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		return y[15:0];
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 100);
	endfunction

	function automatic int ready_len();
		if ($urandom_range(0, 99) < 15)
			return $urandom_range(200, 600);
		return $urandom_range(1, 30);
	endfunction

	function automatic int stall_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return $urandom_range(1, 3);
		if (p < 93)
			return $urandom_range(4, 12);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return SAMPLE_W'($urandom_range(0, 64) - 32);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] rand_step();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return STEP_W'(1);
			2: return '1;
			3: return PHASE_STEP_RST;
			4: return STEP_W'(32768);
			default: return STEP_W'($urandom_range(1, 262143));
		endcase
	endfunction

	function automatic logic [MIX_W-1:0] rand_mix();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return UNITY_Q15;
			2: return MIX_W'($urandom_range(32769, 65535));
			default: return MIX_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// offer one sample beat, return at the falling edge after it is taken
	task automatic put_sample(input logic [SAMPLE_W-1:0] x, input bit has_fixed,
			input logic [SAMPLE_W-1:0] fixed, input int gap);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = x;
		dir_fixed_valid = has_fixed;
		dir_fixed_out = fixed;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// stop sending and wait until every output beat is back
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (expected_out_q.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// scoreboard: check output beats, track register writes, predict input beats
	always @(posedge clk) begin : scoreboard
		logic [SAMPLE_W-1:0] want;
		logic [SAMPLE_W-1:0] pred;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_out_q.size() == 0) begin
					$error("sample_out beat with nothing expected: actual %0d",
						$signed(m_axis_tdata));
					err_cnt++;
				end else begin
					want = expected_out_q.pop_front();
					if (m_axis_tdata !== want) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							$signed(want), $signed(m_axis_tdata));
						err_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PHASE_STEP:    p_step = cfg_data[STEP_W-1:0];
					CFG_MIX_LEVEL:     p_mix = cfg_data[MIX_W-1:0];
					CFG_EFFECT_ENABLE: p_enable = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pred = shift_sample(s_axis_tdata);
				expected_out_q.push_back(dir_fixed_valid ? dir_fixed_out : pred);
			end
		end
	end

	// receiver: random ready bursts and stalls, plus one long hold-off on request
	initial begin : receiver
		bit rx_on;
		int rx_left;
		rx_on = 1'b0;
		rx_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_on = !rx_on;
					rx_left = rx_on ? ready_len() : stall_len();
				end
				m_axis_tready = rx_on;
				rx_left--;
			end
		end
	end

	// run time limit
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int phase_no;
		int len;
		bit en;

		foreach (hann_tab[k])
			hann_tab[k] = hann_calc(k);
		foreach (p_store[k])
			p_store[k] = '0;
		p_wr_pos = 0;
		p_full = 1'b0;
		p_phase = 0;
		p_fade = 0;
		p_step = PHASE_STEP_RST;
		p_mix = MIX_LEVEL_RST;
		p_enable = 1'b0;

		dir_tab = '{
			// bypass after reset copies the input
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h0000, 1'b1, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h7FFF, 1'b1, 16'h7FFF},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h8000, 1'b1, 16'h8000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'hFFFF, 1'b1, 16'hFFFF},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h5A5A, 1'b1, 16'h5A5A},
			// effect on with reset mix, store still filling
			'{ROW_CFG, CFG_EFFECT_ENABLE, 18'd1, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h7FFF, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h8000, 1'b0, 16'h0000},
			// fully dry
			'{ROW_CFG, CFG_MIX_LEVEL, 18'd0, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h8000, 1'b1, 16'h8000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h7FFF, 1'b1, 16'h7FFF},
			// fully wet, nothing to read yet
			'{ROW_CFG, CFG_MIX_LEVEL, 18'd32768, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h7FFF, 1'b1, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h8000, 1'b1, 16'h0000},
			// mix above range acts as fully wet
			'{ROW_CFG, CFG_MIX_LEVEL, 18'h3FFFF, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h1234, 1'b1, 16'h0000},
			// zero step and then the largest step, half mix
			'{ROW_CFG, CFG_PHASE_STEP, 18'd0, 16'h0000, 1'b0, 16'h0000},
			'{ROW_CFG, CFG_MIX_LEVEL, 18'd16384, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'hA5A5, 1'b0, 16'h0000},
			'{ROW_CFG, CFG_PHASE_STEP, 18'h3FFFF, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h0001, 1'b0, 16'h0000},
			// bypass again; a write to the unused index must change nothing
			'{ROW_CFG, CFG_EFFECT_ENABLE, 18'd0, 16'h0000, 1'b0, 16'h0000},
			'{ROW_CFG, CFG_UNUSED_IDX, 18'h3FFFF, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'hFFFE, 1'b1, 16'hFFFE},
			'{ROW_CFG, CFG_PHASE_STEP, 18'd1, 16'h0000, 1'b0, 16'h0000},
			'{ROW_CFG, CFG_EFFECT_ENABLE, 18'd1, 16'h0000, 1'b0, 16'h0000},
			'{ROW_SAMPLE, CFG_PHASE_STEP, '0, 16'h3FFF, 1'b0, 16'h0000}
		};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		foreach (dir_tab[r]) begin
			if (dir_tab[r].kind == ROW_CFG) begin
				drain();
				write_reg(dir_tab[r].idx, dir_tab[r].data);
			end else begin
				put_sample(dir_tab[r].sample, dir_tab[r].has_fixed, dir_tab[r].fixed,
					pick_gap());
			end
		end

		// random part: phases of one register setting each
		sent = 0;
		phase_no = 0;
		while (sent < RAND_ITEMS) begin
			len = $urandom_range(40, 140);
			if (len > RAND_ITEMS - sent)
				len = RAND_ITEMS - sent;
			en = (phase_no < 6) || ($urandom_range(0, 99) < 85);
			drain();
			write_reg(CFG_PHASE_STEP, rand_step());
			write_reg(CFG_MIX_LEVEL, {2'($urandom_range(0, 3)), rand_mix()});
			write_reg(CFG_EFFECT_ENABLE, {17'($urandom), en});
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
			for (int i = 0; i < len; i++) begin
				// long receiver hold-off while beats keep coming back to back
				if (phase_no == 2 && i == 10)
					hold_off_req = 1'b1;
				put_sample(rand_sample(), 1'b0, '0, (phase_no == 2) ? 0 : pick_gap());
				sent++;
			end
			phase_no++;
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
